// File: sv/mfv_pkg.sv
`default_nettype none
package mfv_pkg;

   localparam int HEADER_BYTES = 10;
   localparam int CRC_BYTES = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CHK_ALL_ZERO = 16'h0000;
   localparam logic [15:0] CHK_ALL_ONE = 16'hFFFF;
   localparam logic [7:0] TYPE_RESERVED = 8'h00;
   localparam logic [7:0] TYPE_MAX = 8'h07;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPECTED_MAGIC = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_MESSAGE_BYTES = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PAYLOAD_BYTES = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIG_ENDIAN_WIRE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_CRC = 3'd4;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_SHORT      = 4'd1,
      ST_MAGIC      = 4'd2,
      ST_RESERVED   = 4'd3,
      ST_UNKNOWN    = 4'd4,
      ST_OVERSIZE   = 4'd5,
      ST_TRUNCATED  = 4'd6,
      ST_MISMATCH   = 4'd7,
      ST_SUSPICIOUS = 4'd8,
      ST_CRC        = 4'd9
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  frame_kind;
      logic [15:0] payload_length;
      logic [31:0] sequence_number;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic [16:0] total_bytes;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_magic;
      logic [15:0] min_message_bytes;
      logic [15:0] max_payload_bytes;
      logic        big_endian_wire;
      logic        check_crc;
   } cfg_type;

   // Header fields in arrival order (first byte most significant), then the running CRC.
   typedef struct packed {
      logic [7:0]  magic;
      logic [7:0]  frame_kind;
      logic [15:0] length;
      logic [31:0] seq_field;
      logic [15:0] checksum;
      logic [15:0] crc;
   } header_type;

   // Capture state at the start of every message.
   localparam header_type HEADER_CLEAR = '{
      magic:      8'h00,
      frame_kind: 8'h00,
      length:     16'h0000,
      seq_field:  32'h0000_0000,
      checksum:   16'h0000,
      crc:        CRC_INIT
   };

   // Register values after reset.
   localparam cfg_type CFG_RESET = '{
      expected_magic:    8'h00,
      min_message_bytes: 16'(HEADER_BYTES),
      max_payload_bytes: 16'hFFFF,
      big_endian_wire:   1'b1,
      check_crc:         1'b1
   };

   // One byte of CRC-16/CCITT-FALSE, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage
`default_nettype wire

// File: sv/mfv_capture.sv
`default_nettype none
module mfv_capture #(
   parameter int COUNT_BITS = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire mfv_pkg::req_type       req_item,
   output mfv_pkg::header_type         header_next,
   output logic [COUNT_BITS-1:0]       count_next
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   mfv_pkg::header_type   header_ff;
   mfv_pkg::header_type   header_in;
   mfv_pkg::header_type   header_upd;
   logic [COUNT_BITS-1:0] count_upd;
   logic [7:0]            b;

   assign b = req_item.data_byte;

   // Header field steering by byte position, plus running CRC.
   always_comb begin
      header_upd = header_ff;
      if (count_ff == COUNT_BITS'(0)) begin
         header_upd.magic = b;
      end else if (count_ff == COUNT_BITS'(1)) begin
         header_upd.frame_kind = b;
      end else if (count_ff < COUNT_BITS'(4)) begin
         header_upd.length = {header_ff.length[7:0], b};
      end else if (count_ff < COUNT_BITS'(mfv_pkg::CRC_BYTES)) begin
         header_upd.seq_field = {header_ff.seq_field[23:0], b};
      end else if (count_ff < COUNT_BITS'(mfv_pkg::HEADER_BYTES)) begin
         header_upd.checksum = {header_ff.checksum[7:0], b};
      end
      if (count_ff < COUNT_BITS'(mfv_pkg::CRC_BYTES)) begin
         header_upd.crc = mfv_pkg::crc_byte(header_ff.crc, b);
      end
      count_upd = (count_ff != COUNT_MAX) ? count_ff + COUNT_BITS'(1) : count_ff;
   end

   // The last byte of a message returns the capture state to its reset value.
   always_comb begin
      header_in = header_ff;
      count_in  = count_ff;
      if (accept) begin
         if (req_item.last_byte) begin
            header_in = mfv_pkg::HEADER_CLEAR;
            count_in  = '0;
         end else begin
            header_in = header_upd;
            count_in  = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= mfv_pkg::HEADER_CLEAR;
         count_ff  <= '0;
      end else begin
         header_ff <= header_in;
         count_ff  <= count_in;
      end
   end

   assign header_next = header_upd;
   assign count_next  = count_upd;

endmodule
`default_nettype wire

// File: sv/mfv_check.sv
`default_nettype none
module mfv_check #(
   parameter int COUNT_BITS = 17
) (
   input  wire mfv_pkg::header_type   header,
   input  wire logic [COUNT_BITS-1:0] count,
   input  wire mfv_pkg::cfg_type      cfg,
   output mfv_pkg::rsp_type           result
);

   logic [15:0]           len;
   logic [31:0]           seq;
   logic [15:0]           chk;
   logic [16:0]           expected_total;
   logic [COUNT_BITS-1:0] expected_count;
   logic                  chk_extreme;
   mfv_pkg::status_type   status;

   always_comb begin
      len = cfg.big_endian_wire ? header.length    : mfv_pkg::swap16(header.length);
      seq = cfg.big_endian_wire ? header.seq_field : mfv_pkg::swap32(header.seq_field);
      chk = cfg.big_endian_wire ? header.checksum  : mfv_pkg::swap16(header.checksum);
      expected_total = 17'(mfv_pkg::HEADER_BYTES) + {1'b0, len};
      expected_count = COUNT_BITS'(expected_total);
      chk_extreme = (chk == mfv_pkg::CHK_ALL_ZERO) || (chk == mfv_pkg::CHK_ALL_ONE);

      // First failing check wins.
      if (count < COUNT_BITS'(cfg.min_message_bytes) ||
          count < COUNT_BITS'(mfv_pkg::HEADER_BYTES)) begin
         status = mfv_pkg::ST_SHORT;
      end else if (header.magic != cfg.expected_magic) begin
         status = mfv_pkg::ST_MAGIC;
      end else if (header.frame_kind == mfv_pkg::TYPE_RESERVED) begin
         status = mfv_pkg::ST_RESERVED;
      end else if (header.frame_kind > mfv_pkg::TYPE_MAX) begin
         status = mfv_pkg::ST_UNKNOWN;
      end else if (len > cfg.max_payload_bytes) begin
         status = mfv_pkg::ST_OVERSIZE;
      end else if (count < expected_count) begin
         status = mfv_pkg::ST_TRUNCATED;
      end else if (count > expected_count) begin
         status = mfv_pkg::ST_MISMATCH;
      end else if (cfg.check_crc && chk_extreme && header.crc != chk) begin
         status = mfv_pkg::ST_SUSPICIOUS;
      end else if (cfg.check_crc && header.crc != chk) begin
         status = mfv_pkg::ST_CRC;
      end else begin
         status = mfv_pkg::ST_OK;
      end

      result.status      = status;
      result.total_bytes = count[16:0];
      // A short message reports no header fields.
      if (status == mfv_pkg::ST_SHORT) begin
         result.frame_kind      = '0;
         result.payload_length  = '0;
         result.sequence_number = '0;
         result.received_crc    = '0;
         result.computed_crc    = '0;
      end else begin
         result.frame_kind      = header.frame_kind;
         result.payload_length  = len;
         result.sequence_number = seq;
         result.received_crc    = chk;
         result.computed_crc    = header.crc;
      end
   end

endmodule
`default_nettype wire

// File: sv/message_frame_validator.sv
// The result item of a message is valid in the cycle after its last byte is accepted.
// One byte item per cycle unless stalled; the CRC byte step and header update are combinational.
// A new byte enters in the same cycle that a waiting result item is taken, so
// the input stalls only while a result is held and rsp_ready is low.
// Reset (synchronous, active high) clears the message state and result valid and
// restores the configuration registers to their defaults.
`default_nettype none
module message_frame_validator #(
   parameter int COUNT_BITS = 17
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire mfv_pkg::req_type                     req_item,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output mfv_pkg::rsp_type                          rsp_item,
   input  wire logic                                 csr_write_en,
   input  wire logic [mfv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mfv_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   logic                  accept;
   mfv_pkg::cfg_type      cfg_ff;
   mfv_pkg::cfg_type      cfg_in;
   mfv_pkg::header_type   header_next;
   logic [COUNT_BITS-1:0] count_next;
   mfv_pkg::rsp_type      result;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   mfv_pkg::rsp_type      rsp_ff;
   mfv_pkg::rsp_type      rsp_in;

   // A byte is taken whenever the result register is free or is being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Configuration registers. Writes to an index outside the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            mfv_pkg::CSR_EXPECTED_MAGIC: begin
               cfg_in.expected_magic = csr_write_data[7:0];
            end
            mfv_pkg::CSR_MIN_MESSAGE_BYTES: begin
               cfg_in.min_message_bytes = csr_write_data;
            end
            mfv_pkg::CSR_MAX_PAYLOAD_BYTES: begin
               cfg_in.max_payload_bytes = csr_write_data;
            end
            mfv_pkg::CSR_BIG_ENDIAN_WIRE: begin
               cfg_in.big_endian_wire = csr_write_data[0];
            end
            mfv_pkg::CSR_CHECK_CRC: begin
               cfg_in.check_crc = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mfv_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Header capture and running CRC. It presents the state as it stands after
   // the byte now offered, which the checks below read on the last byte.
   mfv_capture #(
      .COUNT_BITS (COUNT_BITS)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .header_next (header_next),
      .count_next  (count_next)
   );

   // Ordered header checks and byte order correction.
   mfv_check #(
      .COUNT_BITS (COUNT_BITS)
   ) u_check (
      .header (header_next),
      .count  (count_next),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Result register: loaded on the last byte of a message, held until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept && req_item.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire
